// ===== design/ttcbd_pkg.sv =====
// Shared types, register codes and the quarter-wave cosine table for the brake detector.
package ttcbd_pkg;

  // Beam count of the scanner; larger indices are skipped
  localparam int unsigned MaxBeams = 2048;

  // Quarter-wave cosine table: CosDepth + 1 entries in Q15
  localparam int unsigned CosIdxW   = 10;
  localparam int unsigned CosDepth  = 1 << CosIdxW;
  localparam int unsigned CosAddrW  = CosIdxW + 1;
  localparam int unsigned CosEntries = CosDepth + 1;

  // Register indices of the configuration port
  localparam logic [2:0] RegTtc        = 3'd0;
  localparam logic [2:0] RegConeFirst  = 3'd1;
  localparam logic [2:0] RegConeLast   = 3'd2;
  localparam logic [2:0] RegAngleStart = 3'd3;
  localparam logic [2:0] RegAngleStep  = 3'd4;

  // Reset values of the registers
  localparam logic [15:0]        TtcRst        = 16'd500;
  localparam logic [10:0]        ConeFirstRst  = 11'd432;
  localparam logic [10:0]        ConeLastRst   = 11'd647;
  localparam logic signed [15:0] AngleStartRst = -16'sd24510;
  localparam logic [9:0]         AngleStepRst  = 10'd45;

  // Scale of the range side of the compare: mm to um
  localparam logic [10:0] RangeScale = 11'd1000;

  // pi/2 in Q30
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  // Taylor divisors (2n-1)*2n for n = 1..8
  localparam logic [63:0] TaylorDiv [8] = '{64'd2, 64'd12, 64'd30, 64'd56,
                                            64'd90, 64'd132, 64'd182, 64'd240};

  typedef logic [14:0] cos_table_t [CosEntries];

  // Build the table at elaboration: Taylor series in Q30, rounded to Q15
  function automatic cos_table_t cos_table_gen();
    cos_table_t          tab;
    logic [63:0]         x;
    logic [63:0]         x2;
    logic [63:0]         term;
    logic signed [63:0]  sum;
    for (int k = 0; k < CosEntries; k++) begin
      x    = (HalfPiQ30 * 64'(k) + 64'(CosDepth / 2)) / CosDepth;
      x2   = (x * x) >> 30;
      term = 64'd1 << 30;
      sum  = signed'(term);
      for (int n = 0; n < 8; n++) begin
        term = ((term * x2) >> 30) / TaylorDiv[n];
        if (n % 2 == 0) begin
          sum = sum - signed'(term);
        end else begin
          sum = sum + signed'(term);
        end
      end
      if (sum < 0) begin
        sum = 64'sd0;
      end
      sum = (sum + 64'sd16384) >>> 15;
      if (sum > 64'sd32767) begin
        sum = 64'sd32767;
      end
      tab[k] = sum[14:0];
    end
    return tab;
  endfunction

endpackage

// ===== design/ttcbd_cos_rom.sv =====
// Quarter-wave cosine ROM with registered read.
module ttcbd_cos_rom
  import ttcbd_pkg::*;
(
  input  logic                clk_i,
  input  logic [CosAddrW-1:0] addr_i,
  output logic [14:0]         data_o
);

  localparam cos_table_t CosRom = cos_table_gen();

  logic [14:0] data_q;

  // Read one entry a cycle
  always_ff @(posedge clk_i) begin
    data_q <= CosRom[addr_i];
  end

  assign data_o = data_q;

endmodule

// ===== design/ttc_brake_detector.sv =====
// Sequence: a speed update or a skipped beam goes straight to the hand-off; a checked beam
// passes through beam angle, cosine read, range rate, threshold product, compare and
// hand-off. One item is in flight at a time, so a new item is accepted only after the last
// one has handed off its word; a single shared multiplier forms four products per beam.
// A stalled result word holds the block until it is taken.
// Reset (rst_ni, asynchronous, active low) loads the register defaults and clears the
// stored speed, the scan brake latch and the output word; no memory clearing is needed.
module ttc_brake_detector
  import ttcbd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  // input words
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               action_i,
  input  logic signed [15:0] speed_mm_s_i,
  input  logic [10:0]        beam_index_i,
  input  logic [15:0]        range_mm_i,
  input  logic               range_valid_i,
  input  logic               start_of_scan_i,
  // result words
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               brake_o,
  output logic [10:0]        hit_index_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_ANG, S_ROM, S_RATE, S_TTC, S_CMP, S_DONE
  } state_e;

  state_e state_q;

  // Configuration and scan state
  logic [15:0]        ttc_q;
  logic [10:0]        cone_first_q;
  logic [10:0]        cone_last_q;
  logic signed [15:0] angle_start_q;
  logic [9:0]         angle_step_q;
  logic signed [15:0] speed_q;
  logic               braked_q;

  // Result word and output register
  logic               res_brake_q;
  logic [10:0]        res_hit_q;
  logic               out_valid_q;
  logic               out_brake_q;
  logic [10:0]        out_hit_q;

  // Datapath payload
  logic [10:0]        beam_q;
  logic [15:0]        range_q;
  logic [25:0]        lhs_q;
  logic               neg_q;
  logic               rate_pos_q;
  logic signed [49:0] mul_q;

  logic               in_acc;
  logic               cfg_acc;
  logic               skip;
  logic               latch_now;
  logic               hit;
  logic               out_free;
  logic [15:0]        angle;
  logic [1:0]         quad;
  logic [CosIdxW-1:0] cos_idx;
  logic [CosAddrW-1:0] rom_addr;
  logic [14:0]        rom_data;
  logic signed [16:0] cos_s;
  logic signed [32:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [49:0] mul_p;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i & cfg_ready_o;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i & in_ready_o;
  assign out_free    = ~out_valid_q | out_ready_i;

  // Decide at acceptance whether the beam needs checking
  assign latch_now = braked_q & ~start_of_scan_i;
  assign skip = ~range_valid_i | latch_now
              | (32'(beam_index_i) >= MaxBeams)
              | (beam_index_i < cone_first_q) | (beam_index_i > cone_last_q);

  // Beam angle, quadrant and table address
  assign angle    = 16'(angle_start_q) + mul_q[15:0];
  assign quad     = angle[15:14];
  assign cos_idx  = angle[13 -: CosIdxW];
  assign rom_addr = quad[0] ? CosAddrW'(CosDepth) - {1'b0, cos_idx} : {1'b0, cos_idx};

  ttcbd_cos_rom u_cos_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  assign cos_s = neg_q ? -signed'({2'b00, rom_data}) : signed'({2'b00, rom_data});

  // Select operands of the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_ANG: begin
        mul_a = signed'(33'(beam_q));
        mul_b = signed'(17'(angle_step_q));
      end
      S_ROM: begin
        mul_a = signed'(33'(range_q));
        mul_b = signed'(17'(RangeScale));
      end
      S_RATE: begin
        mul_a = 33'(speed_q);
        mul_b = cos_s;
      end
      S_TTC: begin
        mul_a = signed'({2'b00, mul_q[30:0]});
        mul_b = signed'(17'(ttc_q));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Time to collision below the limit: range*1000*32768 < ttc*rate
  assign hit = rate_pos_q & ({5'b0, lhs_q, 15'b0} < mul_q[45:0]);

  // Hold datapath payload
  always_ff @(posedge clk_i) begin
    mul_q <= mul_p;
    if (in_acc) begin
      beam_q  <= beam_index_i;
      range_q <= range_mm_i;
    end
    if (state_q == S_ROM) begin
      neg_q <= quad[1] ^ quad[0];
    end
    if (state_q == S_RATE) begin
      lhs_q <= mul_q[25:0];
    end
    if (state_q == S_TTC) begin
      rate_pos_q <= (mul_q > 50'sd0);
    end
  end

  // Sequence one word, hold state, latch and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      ttc_q         <= TtcRst;
      cone_first_q  <= ConeFirstRst;
      cone_last_q   <= ConeLastRst;
      angle_start_q <= AngleStartRst;
      angle_step_q  <= AngleStepRst;
      speed_q       <= '0;
      braked_q      <= 1'b0;
      res_brake_q   <= 1'b0;
      res_hit_q     <= '0;
      out_valid_q   <= 1'b0;
      out_brake_q   <= 1'b0;
      out_hit_q     <= '0;
    end else begin
      if (cfg_acc) begin
        unique case (cfg_index_i)
          RegTtc:        ttc_q         <= cfg_data_i;
          RegConeFirst:  cone_first_q  <= cfg_data_i[10:0];
          RegConeLast:   cone_last_q   <= cfg_data_i[10:0];
          RegAngleStart: angle_start_q <= signed'(cfg_data_i);
          RegAngleStep:  angle_step_q  <= cfg_data_i[9:0];
          default:       ;
        endcase
      end

      // Drop a taken word unless a new one loads in its place
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            res_brake_q <= 1'b0;
            res_hit_q   <= '0;
            if (!action_i) begin
              speed_q <= speed_mm_s_i;
              state_q <= S_DONE;
            end else begin
              if (start_of_scan_i) begin
                braked_q <= 1'b0;
              end
              state_q <= skip ? S_DONE : S_ANG;
            end
          end
        end
        S_ANG:  state_q <= S_ROM;
        S_ROM:  state_q <= S_RATE;
        S_RATE: state_q <= S_TTC;
        S_TTC:  state_q <= S_CMP;
        S_CMP: begin
          if (hit) begin
            braked_q    <= 1'b1;
            res_brake_q <= 1'b1;
            res_hit_q   <= beam_q;
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_brake_q <= res_brake_q;
            out_hit_q   <= res_hit_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign brake_o     = out_brake_q;
  assign hit_index_o = out_hit_q;

`ifndef SYNTHESIS
  // A raised brake names a beam inside the cone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && brake_o) |-> (hit_index_o >= cone_first_q && hit_index_o <= cone_last_q))
    else $error("brake raised for a beam outside the cone");

  // No brake means the index reads zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !brake_o) |-> (hit_index_o == '0))
    else $error("hit index set without brake");

  // A start-of-scan sample clears the latch
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && action_i && start_of_scan_i) |=> !braked_q)
    else $error("scan latch not cleared at start of scan");

  // Hold a waiting result word unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(brake_o) && $stable(hit_index_o)))
    else $error("waiting result word changed or dropped");
`endif

endmodule

// ===== test/tb_ttc_brake_detector.sv =====
// Testbench for the time-to-collision brake detector: directed cases, random scans, backpressure.
`timescale 1ns / 1ps

module tb_ttc_brake_detector;
  import ttcbd_pkg::*;

  // Item kinds on the action field
  localparam logic ActSpeed = 1'b0;
  localparam logic ActBeam  = 1'b1;

  // Register indices the block does not decode
  localparam logic [2:0] RegUnusedLo = 3'd5;
  localparam logic [2:0] RegUnusedHi = 3'd7;

  // Cosine series constants: pi/2 in Q30 and the quarter-wave step count
  localparam longint unsigned PiHalfQ30 = 64'd1686629713;
  localparam int unsigned     CosSteps  = 1024;

  // Cycles with no handshake on any port before the run is abandoned
  localparam int StallLimit = 2000;
  // Receiver hold-off used to fill the block
  localparam int HoldOff    = 300;

  typedef struct packed {
    logic               action;
    logic signed [15:0] speed;
    logic [10:0]        beam;
    logic [15:0]        rng;
    logic               rvalid;
    logic               sos;
  } beam_word_t;

  typedef struct packed {
    logic        brake;
    logic [10:0] hit;
  } brake_word_t;

  localparam int NoiseBits = $bits(beam_word_t);

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               cfg_valid_i     = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i     = '0;
  logic [15:0]        cfg_data_i      = '0;
  logic               in_valid_i      = 1'b0;
  logic               in_ready_o;
  logic               action_i        = 1'b0;
  logic signed [15:0] speed_mm_s_i    = '0;
  logic [10:0]        beam_index_i    = '0;
  logic [15:0]        range_mm_i      = '0;
  logic               range_valid_i   = 1'b0;
  logic               start_of_scan_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i     = 1'b0;
  logic               brake_o;
  logic [10:0]        hit_index_o;

  // Predictor copy of the registers and the block state
  logic [15:0]        ttc_ms      = 16'd500;
  logic [10:0]        cone_lo     = 11'd432;
  logic [10:0]        cone_hi     = 11'd647;
  logic [15:0]        ang0        = 16'hA042;
  logic [9:0]         ang_step    = 10'd45;
  logic signed [15:0] sp_mm_s     = '0;
  logic               scan_braked = 1'b0;

  brake_word_t brake_expect_q[$];
  int          mismatch_count = 0;
  int          result_count   = 0;
  int          quiet_cycles   = 0;
  int          sink_hold      = 0;
  bit          free_run       = 1'b0;

  ttc_brake_detector DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .speed_mm_s_i   (speed_mm_s_i),
    .beam_index_i   (beam_index_i),
    .range_mm_i     (range_mm_i),
    .range_valid_i  (range_valid_i),
    .start_of_scan_i(start_of_scan_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .brake_o        (brake_o),
    .hit_index_o    (hit_index_o)
  );

  always #5 clk_i = ~clk_i;

  // Q15 cosine of a binary angle, series evaluated in Q30 on a quarter wave
  function automatic int beam_cosine(logic [15:0] ang);
    logic [1:0]       quad;
    int unsigned      k;
    longint unsigned  x;
    longint unsigned  x2;
    longint unsigned  term;
    longint           acc;
    quad = ang[15:14];
    k    = int'(ang[13:4]);
    if (quad[0]) begin
      k = CosSteps - k;
    end
    x    = (PiHalfQ30 * 64'(k) + 64'(CosSteps / 2)) / 64'(CosSteps);
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    acc  = longint'(term);
    for (int n = 1; n <= 8; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    acc = (acc + 64'sd16384) >>> 15;
    if (acc > 32767) begin
      acc = 32767;
    end
    return (quad[1] ^ quad[0]) ? -int'(acc) : int'(acc);
  endfunction

  // Advance the predictor by one accepted word and return the result it causes
  function automatic brake_word_t predict_brake(beam_word_t w);
    brake_word_t     r;
    logic [15:0]     ang;
    longint          rate;
    longint unsigned lhs;
    longint unsigned rhs;
    r = '0;
    if (w.action == ActSpeed) begin
      sp_mm_s = w.speed;
      return r;
    end
    // a new scan clears the latch before this beam is looked at
    if (w.sos) begin
      scan_braked = 1'b0;
    end
    if (!w.rvalid || scan_braked || w.beam >= MaxBeams) begin
      return r;
    end
    if (w.beam < cone_lo || w.beam > cone_hi) begin
      return r;
    end
    ang  = ang0 + 16'(32'(w.beam) * 32'(ang_step));
    rate = longint'(sp_mm_s) * longint'(beam_cosine(ang));
    if (rate <= 0) begin
      return r;
    end
    lhs = 64'(w.rng) * 64'd1000 * 64'd32768;
    rhs = 64'(ttc_ms) * 64'(rate);
    if (lhs < rhs) begin
      scan_braked = 1'b1;
      r.brake     = 1'b1;
      r.hit       = w.beam;
    end
    return r;
  endfunction

  function automatic beam_word_t speed_word(logic [15:0] speed);
    beam_word_t w;
    // unused fields carry noise
    w        = NoiseBits'({$urandom, $urandom});
    w.action = ActSpeed;
    w.speed  = speed;
    return w;
  endfunction

  function automatic beam_word_t beam_word(logic [10:0] beam, logic [15:0] rng,
                                           logic rvalid, logic sos);
    beam_word_t w;
    w        = NoiseBits'({$urandom, $urandom});
    w.action = ActBeam;
    w.beam   = beam;
    w.rng    = rng;
    w.rvalid = rvalid;
    w.sos    = sos;
    return w;
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 40) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  // Offer one word, hold it until accepted, then record what it should cause
  task automatic send_word(beam_word_t w);
    while (!free_run && $urandom_range(0, 99) < 22) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    action_i        <= w.action;
    speed_mm_s_i    <= w.speed;
    beam_index_i    <= w.beam;
    range_mm_i      <= w.rng;
    range_valid_i   <= w.rvalid;
    start_of_scan_i <= w.sos;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    brake_expect_q.push_back(predict_brake(w));
  endtask

  // Drain the block, then write all registers back to back
  task automatic write_regs(input logic [15:0] ttc, input logic [10:0] first,
                            input logic [10:0] last, input logic [15:0] start,
                            input logic [9:0] step);
    logic [2:0]  idx [6];
    logic [15:0] dat [6];
    logic [15:0] junk;
    logic [2:0]  tmp_idx;
    logic [15:0] tmp_dat;
    int          n;
    int          slot;
    junk   = 16'($urandom);
    idx[0] = RegTtc;        dat[0] = ttc;
    idx[1] = RegConeFirst;  dat[1] = {junk[15:11], first};
    idx[2] = RegConeLast;   dat[2] = {junk[10:6], last};
    idx[3] = RegAngleStart; dat[3] = start;
    idx[4] = RegAngleStep;  dat[4] = {junk[5:0], step};
    n = 5;
    // now and then slip in a write to an undecoded index
    if ($urandom_range(0, 1) == 1) begin
      slot      = $urandom_range(0, 4);
      idx[5]    = idx[slot];
      dat[5]    = dat[slot];
      idx[slot] = 3'($urandom_range(RegUnusedLo, RegUnusedHi));
      dat[slot] = 16'($urandom);
      n = 6;
    end
    in_valid_i <= 1'b0;
    while (brake_expect_q.size() != 0) begin
      @(posedge clk_i);
    end
    for (int i = 0; i < n; i++) begin
      tmp_idx = idx[i];
      tmp_dat = dat[i];
      cfg_valid_i <= 1'b1;
      cfg_index_i <= tmp_idx;
      cfg_data_i  <= tmp_dat;
      @(posedge clk_i);
      while (!cfg_ready_o) begin
        @(posedge clk_i);
      end
      case (tmp_idx)
        RegTtc:        ttc_ms   = tmp_dat;
        RegConeFirst:  cone_lo  = tmp_dat[10:0];
        RegConeLast:   cone_hi  = tmp_dat[10:0];
        RegAngleStart: ang0     = tmp_dat;
        RegAngleStep:  ang_step = tmp_dat[9:0];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly well-formed scans with random content, some speed updates and noise
  task automatic run_scans(input int n_items);
    int          sent;
    int          roll;
    int          len;
    longint      reach;
    int          top;
    logic [10:0] beam;
    logic [15:0] rng;
    logic        sos;
    beam_word_t  noise;
    sent = 0;
    while (sent < n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        if (roll < 6) begin
          send_word(speed_word(16'($urandom_range(1, 32767))));
        end else begin
          send_word(speed_word(16'($urandom)));
        end
        sent++;
      end else if (roll < 16) begin
        noise = NoiseBits'({$urandom, $urandom});
        send_word(noise);
        sent++;
      end else begin
        len = $urandom_range(3, 30);
        if (cone_lo <= cone_hi && $urandom_range(0, 9) != 0) begin
          beam = 11'($urandom_range(cone_lo, cone_hi));
        end else begin
          beam = 11'($urandom);
        end
        // range that roughly matches the threshold at the current speed
        reach = (sp_mm_s > 0) ? (longint'(ttc_ms) * longint'(sp_mm_s)) / 1000 : 0;
        top   = (reach * 2 + 16 > 65535) ? 65535 : int'(reach * 2 + 16);
        for (int j = 0; j < len && sent < n_items; j++) begin
          roll = $urandom_range(0, 9);
          if (roll < 5) begin
            rng = 16'($urandom_range(0, top));
          end else if (roll < 8) begin
            rng = 16'($urandom);
          end else begin
            rng = 16'($urandom_range(0, 63));
          end
          // a scan now and then starts without its mark, or gets a stray one
          sos = (j == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 29) == 0);
          send_word(beam_word(beam, rng, $urandom_range(0, 9) != 0, sos));
          sent++;
          beam = beam + 11'($urandom_range(1, 8));
        end
      end
    end
  endtask

  task automatic test_reset_settings();
    beam_word_t w;
    // reset speed is zero: nothing can close in
    send_word(beam_word(11'd540, 16'd0, 1'b1, 1'b1));
    send_word(speed_word(16'sd32767));
    send_word(beam_word(11'd540, 16'd0, 1'b1, 1'b1));
    // latched: later beams of the scan stay quiet
    send_word(beam_word(11'd541, 16'd0, 1'b1, 1'b0));
    // a scan mark on a speed update must not clear the latch
    w     = speed_word(16'sd32767);
    w.sos = 1'b1;
    send_word(w);
    send_word(beam_word(11'd542, 16'd0, 1'b1, 1'b0));
    // invalid beam on a new scan: latch cleared but beam skipped
    send_word(beam_word(11'd540, 16'd0, 1'b0, 1'b1));
    send_word(beam_word(11'd543, 16'hFFFF, 1'b1, 1'b0));
    send_word(beam_word(11'd431, 16'd0, 1'b1, 1'b0));
    send_word(beam_word(11'd647, 16'd0, 1'b1, 1'b0));
    send_word(beam_word(11'd432, 16'd0, 1'b1, 1'b1));
    // reversing: range rate negative
    send_word(speed_word(-16'sd32768));
    send_word(beam_word(11'd500, 16'd0, 1'b1, 1'b1));
    send_word(beam_word(11'd2047, 16'd0, 1'b1, 1'b1));
    send_word(speed_word(16'sd1));
    send_word(beam_word(11'd540, 16'd0, 1'b1, 1'b1));
  endtask

  task automatic test_extreme_settings();
    // full cone, widest step, start at the top of the signed range
    write_regs(16'hFFFF, 11'd0, 11'd2047, 16'h7FFF, 10'd1023);
    send_word(speed_word(16'sd32767));
    // beam facing away, then a wrapped angle in the first quadrant
    send_word(beam_word(11'd0, 16'hFFFF, 1'b1, 1'b1));
    send_word(beam_word(11'd33, 16'hFFFF, 1'b1, 1'b0));
    send_word(beam_word(11'd2047, 16'd0, 1'b1, 1'b1));
  endtask

  task automatic test_empty_cone();
    // first beyond last: no beam is ever checked
    write_regs(16'hFFFF, 11'd2047, 11'd0, 16'h8000, 10'd0);
    send_word(speed_word(-16'sd32768));
    send_word(beam_word(11'd0, 16'd0, 1'b1, 1'b1));
    send_word(beam_word(11'd2047, 16'd0, 1'b1, 1'b1));
    // zero threshold never brakes, even at zero range
    write_regs(16'd0, 11'd1000, 11'd1000, 16'h8000, 10'd0);
    send_word(beam_word(11'd1000, 16'd0, 1'b1, 1'b1));
    write_regs(16'd1, 11'd1000, 11'd1000, 16'h8000, 10'd0);
    send_word(beam_word(11'd1000, 16'd1, 1'b1, 1'b1));
  endtask

  task automatic test_random_settings();
    logic [10:0] lo;
    logic [10:0] hi;
    logic [15:0] ttc;
    for (int p = 0; p < 6; p++) begin
      lo  = 11'($urandom);
      hi  = 11'($urandom);
      ttc = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000));
      case (p)
        0: write_regs(16'd500, 11'd432, 11'd647, -16'sd24510, 10'd45);
        1: write_regs(16'hFFFF, 11'd0, 11'd2047, 16'h8000, 10'd1023);
        2: write_regs(16'd0, 11'd2047, 11'd2047, 16'h7FFF, 10'd0);
        3: begin
          if (lo == hi) begin
            hi = lo ^ 11'd1;
          end
          write_regs(ttc, (lo > hi) ? lo : hi, (lo > hi) ? hi : lo, 16'($urandom),
                     10'($urandom));
        end
        default: begin
          write_regs(ttc, (lo < hi) ? lo : hi, (lo < hi) ? hi : lo, 16'($urandom),
                     10'($urandom));
        end
      endcase
      run_scans(170);
    end
  endtask

  task automatic test_steady_stream();
    write_regs(16'd800, 11'd300, 11'd800, -16'sd24510, 10'd45);
    free_run = 1'b1;
    run_scans(150);
    free_run = 1'b0;
  endtask

  task automatic test_backpressure();
    // receiver holds off while the sender keeps offering words
    sink_hold = HoldOff;
    free_run  = 1'b1;
    run_scans(40);
    free_run  = 1'b0;
  endtask

  // Compare each accepted result word with the oldest expectation; drive ready
  initial begin : result_monitor
    brake_word_t want;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        result_count++;
        if (brake_expect_q.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing expected", result_count));
        end else begin
          want = brake_expect_q.pop_front();
          if (brake_o !== want.brake) begin
            report_mismatch($sformatf("result %0d brake %b, want %b",
                                      result_count, brake_o, want.brake));
          end
          if (hit_index_o !== want.hit) begin
            report_mismatch($sformatf("result %0d hit_index %0d, want %0d",
                                      result_count, hit_index_o, want.hit));
          end
        end
      end
      if (sink_hold > 0) begin
        sink_hold--;
        out_ready_i <= 1'b0;
      end else if (free_run) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= 22);
      end
    end
  end

  // Abandon the run when no port moves a word for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("tb_ttc_brake_detector failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_settings();
    test_extreme_settings();
    test_empty_cone();
    test_random_settings();
    test_steady_stream();
    test_backpressure();
    in_valid_i <= 1'b0;
    while (brake_expect_q.size() != 0) begin
      @(posedge clk_i);
    end
    // catch any stray word after the last expected one
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_ttc_brake_detector passed");
    end else begin
      $display("tb_ttc_brake_detector failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/ttcbd_pkg.sv
design/ttcbd_cos_rom.sv
design/ttc_brake_detector.sv
test/tb_ttc_brake_detector.sv
